FILE: rtl/mi4_pkg.sv
`timescale 1ns / 1ps
package mi4_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [14:0] elem_t;
  typedef elem_t [15:0] mat_t;

  // write side of the matrix queue
  typedef struct packed {
    logic push;
    mat_t data;
  } qpush_t;

  // read side of the matrix queue
  typedef struct packed {
    logic empty;
    logic full;
    mat_t data;
  } qstat_t;

endpackage

FILE: rtl/mi4_front.sv
`timescale 1ns / 1ps
module mi4_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mi4_pkg::elem_t    element,
  input  logic              last_element,
  output mi4_pkg::qpush_t   qin
);

  mi4_pkg::mat_t mat;
  mi4_pkg::mat_t mat_next;
  logic [3:0]    load_count;

  always_comb begin
    mat_next = mat;
    mat_next[load_count] = element;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= last_element ? 4'd0 : load_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mat <= mat_next;
    end
  end

  // the whole matrix, new word included, goes to the queue on the last word
  assign qin.push = accept && last_element;
  assign qin.data = mat_next;

endmodule

FILE: rtl/mi4_queue.sv
`timescale 1ns / 1ps
module mi4_queue (
  input  logic              clk,
  input  logic              rst,
  input  mi4_pkg::qpush_t   qin,
  input  logic              pop,
  output mi4_pkg::qstat_t   qout
);

  localparam int PW = (mi4_pkg::QUEUE_DEPTH > 1) ? $clog2(mi4_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mi4_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(mi4_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P = PW'(mi4_pkg::QUEUE_DEPTH - 1);

  mi4_pkg::mat_t entries [mi4_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign qout.empty = (count == '0);
  assign qout.full  = (count == DEPTH_C);
  assign qout.data  = entries[rptr];
  assign do_push    = qin.push && !qout.full;
  assign do_pop     = pop && !qout.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_P) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_P) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= qin.data;
    end
  end

endmodule

FILE: rtl/mi4_back.sv
`timescale 1ns / 1ps
module mi4_back (
  input  logic                clk,
  input  logic                rst,
  input  mi4_pkg::qstat_t     qout,
  output logic                pop,
  output logic                result_valid,
  output logic signed [31:0]  inverse_element,
  output logic [3:0]          element_index,
  output logic                singular,
  output logic                saturated,
  output logic                last_result
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COF  = 5'b00010,
    S_DET  = 5'b00100,
    S_DIVI = 5'b01000,
    S_DIVR = 5'b10000
  } bstate_t;

  bstate_t              state;
  mi4_pkg::mat_t        mat;
  logic [3:0]           ci;
  logic [3:0]           st;
  logic signed [29:0]   t;
  logic signed [30:0]   d;
  logic signed [47:0]   acc;
  logic signed [45:0]   cof [16];
  logic signed [61:0]   det;
  logic [3:0]           k;
  logic [5:0]           bitc;
  logic [60:0]          rem;
  logic [60:0]          den;
  logic [32:0]          nsh;
  logic [31:0]          q;
  logic                 neg;
  logic                 over;

  // element (a,b) of the 3x3 minor that drops row ci[3:2] and column ci[1:0]
  function automatic mi4_pkg::elem_t mel(input mi4_pkg::mat_t m, input logic [3:0] c,
                                         input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    logic [1:0] cc;
    r  = (a >= c[3:2]) ? a + 2'd1 : a;
    cc = (b >= c[1:0]) ? b + 2'd1 : b;
    return m[{r, cc}];
  endfunction

  mi4_pkg::elem_t       opa;
  mi4_pkg::elem_t       opb;
  logic signed [29:0]   p;
  logic signed [45:0]   pd;

  always_comb begin
    opa = mel(mat, ci, 2'd1, 2'd1);
    opb = mel(mat, ci, 2'd2, 2'd2);
    case (st)
      4'd1:    begin opa = mel(mat, ci, 2'd1, 2'd2); opb = mel(mat, ci, 2'd2, 2'd1); end
      4'd2:    begin opa = mel(mat, ci, 2'd0, 2'd0); end
      4'd3:    begin opa = mel(mat, ci, 2'd1, 2'd0); opb = mel(mat, ci, 2'd2, 2'd2); end
      4'd4:    begin opa = mel(mat, ci, 2'd1, 2'd2); opb = mel(mat, ci, 2'd2, 2'd0); end
      4'd5:    begin opa = mel(mat, ci, 2'd0, 2'd1); end
      4'd6:    begin opa = mel(mat, ci, 2'd1, 2'd0); opb = mel(mat, ci, 2'd2, 2'd1); end
      4'd7:    begin opa = mel(mat, ci, 2'd1, 2'd1); opb = mel(mat, ci, 2'd2, 2'd0); end
      4'd8:    begin opa = mel(mat, ci, 2'd0, 2'd2); end
      default: begin end
    endcase
    p  = opa * opb;
    pd = opa * d;
  end

  // determinant: each 46-bit cofactor is split into two halves for the multiplier
  logic [1:0]           dj;
  logic signed [45:0]   dcof;
  mi4_pkg::elem_t       dm;
  logic signed [37:0]   dprod_hi;
  logic signed [38:0]   dprod_lo;
  logic signed [61:0]   dterm;

  always_comb begin
    dj       = st[2:1];
    dcof     = cof[{2'b00, dj}];
    dm       = mat[{2'b00, dj}];
    dprod_hi = dm * $signed(dcof[45:23]);
    dprod_lo = dm * $signed({1'b0, dcof[22:0]});
    dterm    = st[0] ? 62'(dprod_lo) : {dprod_hi[37], dprod_hi, 23'b0};
  end

  // division: result (r,c) takes cofactor (c,r)
  logic signed [45:0]   src;
  logic [45:0]          nabs;
  logic [60:0]          dabs;
  logic [61:0]          trial;
  logic                 ge;
  logic [32:0]          qf;
  logic [31:0]          qneg;

  always_comb begin
    src   = cof[{k[1:0], k[3:2]}];
    nabs  = src[45] ? 46'(-src) : 46'(src);
    dabs  = det[61] ? 61'(-det) : 61'(det);
    trial = {rem, nsh[32]};
    ge    = trial >= {1'b0, den};
    qf    = {q, ge};
    qneg  = 32'(~qf + 33'd1);
  end

  assign pop = (state == S_IDLE) && !qout.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!qout.empty) begin
            state <= S_COF;
          end
        end
        S_COF: begin
          if (st == 4'd9 && ci == 4'd15) begin
            state <= S_DET;
          end
        end
        S_DET: begin
          if (st == 4'd7) begin
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (det == '0) begin
            result_valid <= 1'b1;
            if (k == 4'd15) begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (bitc == 6'd32) begin
            result_valid <= 1'b1;
            state        <= (k == 4'd15) ? S_IDLE : S_DIVI;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mat <= qout.data;
        ci  <= '0;
        st  <= '0;
      end
      S_COF: begin
        case (st)
          4'd0, 4'd3, 4'd6: t <= p;
          4'd1, 4'd4, 4'd7: d <= 31'(t) - 31'(p);
          4'd2:             acc <= 48'(pd);
          4'd5:             acc <= acc - 48'(pd);
          4'd8:             acc <= acc + 48'(pd);
          default: begin
            cof[ci] <= (ci[2] ^ ci[0]) ? 46'(-acc) : 46'(acc);
          end
        endcase
        if (st == 4'd9) begin
          st  <= '0;
          ci  <= ci + 4'd1;
          det <= '0;
        end else begin
          st <= st + 4'd1;
        end
      end
      S_DET: begin
        det <= det + dterm;
        st  <= st + 4'd1;
        k   <= '0;
      end
      S_DIVI: begin
        neg  <= src[45] ^ det[61];
        den  <= dabs;
        over <= {21'b0, nabs} >= {dabs, 6'b0};
        rem  <= {21'b0, nabs[45:6]};
        nsh  <= {nabs[5:0], 27'b0};
        q    <= '0;
        bitc <= '0;
        if (det == '0) begin
          inverse_element <= '0;
          element_index   <= k;
          singular        <= 1'b1;
          saturated       <= 1'b0;
          last_result     <= (k == 4'd15);
          k               <= k + 4'd1;
        end
      end
      S_DIVR: begin
        rem  <= ge ? 61'(trial - {1'b0, den}) : trial[60:0];
        q    <= qf[31:0];
        nsh  <= {nsh[31:0], 1'b0};
        bitc <= bitc + 6'd1;
        if (bitc == 6'd32) begin
          element_index <= k;
          singular      <= 1'b0;
          last_result   <= (k == 4'd15);
          k             <= k + 4'd1;
          if (!neg) begin
            if (over || qf > 33'h07FFFFFFF) begin
              inverse_element <= 32'sh7FFFFFFF;
              saturated       <= 1'b1;
            end else begin
              inverse_element <= qf[31:0];
              saturated       <= 1'b0;
            end
          end else begin
            if (over || qf > 33'h080000000) begin
              inverse_element <= 32'sh80000000;
              saturated       <= 1'b1;
            end else begin
              inverse_element <= qneg;
              saturated       <= 1'b0;
            end
          end
        end
      end
      default: begin end
    endcase
  end

endmodule

FILE: rtl/matrix_inverse_4x4_core.sv
`timescale 1ns / 1ps
// Takes one word per cycle while busy is low; words queue up to two whole matrices ahead
// of the solver. Solver: picks up a matrix, works out the sixteen cofactors on two shared
// multipliers, then the determinant, then each result in turn (bit-serial 33-step divider).
// A singular matrix skips the divider for all sixteen results; the receiver cannot stall.
// Synchronous active-high reset empties the queue and clears the load position.
module matrix_inverse_4x4_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [14:0] element,
  input  logic               last_element,
  output logic               result_valid,
  output logic signed [31:0] inverse_element,
  output logic [3:0]         element_index,
  output logic               singular,
  output logic               saturated,
  output logic               last_result
);

  mi4_pkg::qpush_t qin;
  mi4_pkg::qstat_t qout;
  logic            pop;
  logic            accept;

  assign busy   = qout.full;
  assign accept = start && !busy;

  mi4_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .element      (element),
    .last_element (last_element),
    .qin          (qin)
  );

  mi4_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .qin  (qin),
    .pop  (pop),
    .qout (qout)
  );

  mi4_back u_back (
    .clk             (clk),
    .rst             (rst),
    .qout            (qout),
    .pop             (pop),
    .result_valid    (result_valid),
    .inverse_element (inverse_element),
    .element_index   (element_index),
    .singular        (singular),
    .saturated       (saturated),
    .last_result     (last_result)
  );

endmodule
